// ===== src/rbst_pkg.sv =====
// types and constants shared by the ray versus box slab test
package rbst_pkg;

	localparam int NUM_AXES  = 3;
	localparam int NUM_REGS  = 2 * NUM_AXES;
	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = DIFF_W + COORD_W;
	localparam int FRAC_BITS = 16;
	localparam int T_W       = 48;
	localparam int INDEX_W   = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [T_W-1:0]     t_t;
	typedef logic [INDEX_W-1:0]        reg_index_t;

	localparam t_t T_MAX_VAL = {1'b0, {(T_W-1){1'b1}}};
	localparam t_t T_MIN_VAL = {1'b1, {(T_W-1){1'b0}}};

	localparam coord_t INV_POS_INF = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t INV_NEG_INF = {1'b1, {(COORD_W-1){1'b0}}};

	localparam reg_index_t REG_BOX_MIN_X = 3'd0;
	localparam reg_index_t REG_BOX_MIN_Y = 3'd1;
	localparam reg_index_t REG_BOX_MIN_Z = 3'd2;
	localparam reg_index_t REG_BOX_MAX_X = 3'd3;
	localparam reg_index_t REG_BOX_MAX_Y = 3'd4;
	localparam reg_index_t REG_BOX_MAX_Z = 3'd5;

endpackage

// ===== src/ray_box_slab_test.sv =====
// ray versus axis-aligned box slab test, six stage pipeline
//
// One ray transaction on the ray channel (origin and inverse direction per
// axis, signed Q16.16) gives one result transaction on the res channel: hit
// is 1 when the ray meets the box at a nonnegative distance. The box corners
// sit in six registers written through cfg_wr_en / cfg_index / cfg_data;
// an index of six or above is ignored. Write them only while the pipe is
// empty.
// The ray moves through stages one to six in order; res_valid is the valid bit
// of stage six, and hit is registered there.
// A new ray is taken every cycle, one ray per clock, while ray_stall is low,
// since every stage is a full register stage; stage 2 holds the 33 by 32 bit
// multipliers (six multipliers, one per slab plane).
// Each stage moves on when it is empty or the stage after it moves, so
// bubbles close up. When res_stall holds the result, rays are still taken
// until all six stages are full; then ray_stall rises.
// Reset clears all stage valid bits and sets every box corner to zero.
module ray_box_slab_test (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ray_valid,
	output logic                     ray_stall,
	input  rbst_pkg::coord_t         origin_x,
	input  rbst_pkg::coord_t         origin_y,
	input  rbst_pkg::coord_t         origin_z,
	input  rbst_pkg::coord_t         inv_dir_x,
	input  rbst_pkg::coord_t         inv_dir_y,
	input  rbst_pkg::coord_t         inv_dir_z,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic                     hit,
	input  logic                     cfg_wr_en,
	input  rbst_pkg::reg_index_t     cfg_index,
	input  rbst_pkg::coord_t         cfg_data
);

	rbst_pkg::coord_t box_q [rbst_pkg::NUM_REGS];

	rbst_pkg::coord_t org   [rbst_pkg::NUM_AXES];
	rbst_pkg::coord_t inv   [rbst_pkg::NUM_AXES];

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	logic en1, en2, en3, en4, en5, en6;

	rbst_pkg::diff_t  diff_s1 [2][rbst_pkg::NUM_AXES];
	rbst_pkg::coord_t inv_s1  [rbst_pkg::NUM_AXES];

	rbst_pkg::prod_t  prod_s2 [2][rbst_pkg::NUM_AXES];
	logic             zero_s2 [2][rbst_pkg::NUM_AXES];
	logic             neg_s2  [2][rbst_pkg::NUM_AXES];
	logic             inf_s2  [rbst_pkg::NUM_AXES];

	rbst_pkg::t_t     t_s3    [2][rbst_pkg::NUM_AXES];

	rbst_pkg::t_t     lo_s4   [rbst_pkg::NUM_AXES];
	rbst_pkg::t_t     hi_s4   [rbst_pkg::NUM_AXES];

	rbst_pkg::t_t     tmin_s5;
	rbst_pkg::t_t     tmax_s5;

	logic             hit_s6;

	rbst_pkg::t_t     t_next   [2][rbst_pkg::NUM_AXES];
	rbst_pkg::t_t     tmin_next;
	rbst_pkg::t_t     tmax_next;
	rbst_pkg::t_t     tmin_clamp;

	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign inv[0] = inv_dir_x;
	assign inv[1] = inv_dir_y;
	assign inv[2] = inv_dir_z;

	// stage enables, a stage loads when empty or when its successor moves
	assign en6 = !v6_s6 || !res_stall;
	assign en5 = !v5_s5 || en6;
	assign en4 = !v4_s4 || en5;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;

	assign ray_stall = !en1;
	assign res_valid = v6_s6;
	assign hit       = hit_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rbst_pkg::NUM_REGS; i++) begin
				box_q[i] <= '0;
			end
		end else if (cfg_wr_en && (cfg_index <= rbst_pkg::REG_BOX_MAX_Z)) begin
			box_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= ray_valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
			if (en6) v6_s6 <= v5_s5;
		end
	end

	// stage 1: slab plane minus origin
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
				for (int b = 0; b < 2; b++) begin
					diff_s1[b][a] <= rbst_pkg::diff_t'(box_q[b * rbst_pkg::NUM_AXES + a])
						- rbst_pkg::diff_t'(org[a]);
				end
				inv_s1[a] <= inv[a];
			end
		end
	end

	// stage 2: full product and special case flags
	always_ff @(posedge clk) begin
		if (en2) begin
			for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
				for (int b = 0; b < 2; b++) begin
					prod_s2[b][a] <= rbst_pkg::prod_t'(diff_s1[b][a])
						* rbst_pkg::prod_t'(inv_s1[a]);
					zero_s2[b][a] <= (diff_s1[b][a] == '0);
					neg_s2[b][a]  <= diff_s1[b][a][rbst_pkg::DIFF_W-1]
						^ inv_s1[a][rbst_pkg::COORD_W-1];
				end
				inf_s2[a] <= (inv_s1[a] == rbst_pkg::INV_POS_INF)
					|| (inv_s1[a] == rbst_pkg::INV_NEG_INF);
			end
		end
	end

	// stage 3: floor shift and saturate to Q32.16
	always_comb begin
		rbst_pkg::prod_t sh;
		for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
			for (int b = 0; b < 2; b++) begin
				sh = prod_s2[b][a] >>> rbst_pkg::FRAC_BITS;
				if (zero_s2[b][a]) begin
					t_next[b][a] = '0;
				end else if (inf_s2[a]) begin
					t_next[b][a] = neg_s2[b][a] ? rbst_pkg::T_MIN_VAL : rbst_pkg::T_MAX_VAL;
				end else if (sh > rbst_pkg::prod_t'(rbst_pkg::T_MAX_VAL)) begin
					t_next[b][a] = rbst_pkg::T_MAX_VAL;
				end else if (sh < rbst_pkg::prod_t'(rbst_pkg::T_MIN_VAL)) begin
					t_next[b][a] = rbst_pkg::T_MIN_VAL;
				end else begin
					t_next[b][a] = sh[rbst_pkg::T_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			t_s3 <= t_next;
		end
	end

	// stage 4: near and far plane per axis
	always_ff @(posedge clk) begin
		if (en4) begin
			for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
				if (t_s3[0][a] < t_s3[1][a]) begin
					lo_s4[a] <= t_s3[0][a];
					hi_s4[a] <= t_s3[1][a];
				end else begin
					lo_s4[a] <= t_s3[1][a];
					hi_s4[a] <= t_s3[0][a];
				end
			end
		end
	end

	// stage 5: entry and exit over the three axes
	always_comb begin
		tmin_next = lo_s4[0];
		tmax_next = hi_s4[0];
		for (int a = 1; a < rbst_pkg::NUM_AXES; a++) begin
			if (lo_s4[a] > tmin_next) tmin_next = lo_s4[a];
			if (hi_s4[a] < tmax_next) tmax_next = hi_s4[a];
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			tmin_s5 <= tmin_next;
			tmax_s5 <= tmax_next;
		end
	end

	// stage 6: clamp entry at zero and compare
	assign tmin_clamp = tmin_s5[rbst_pkg::T_W-1] ? '0 : tmin_s5;

	always_ff @(posedge clk) begin
		if (en6) begin
			hit_s6 <= (tmax_s5 >= tmin_clamp);
		end
	end

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		ray_stall |-> (v1_s1 && v2_s2 && v3_s3 && v4_s4 && v5_s5 && v6_s6 && res_stall))
		else $error("ray_stall raised with a free pipeline stage");

	a_slab_order: assert property (@(posedge clk) disable iff (!arst_n)
		v4_s4 |-> (lo_s4[0] <= hi_s4[0]) && (lo_s4[1] <= hi_s4[1]) && (lo_s4[2] <= hi_s4[2]))
		else $error("near plane beyond far plane");

	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(en5 && v4_s4) |=> (tmin_s5 >= $past(lo_s4[0])) && (tmax_s5 <= $past(hi_s4[0])))
		else $error("entry or exit does not bound the x slab");

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_s2 && !en3) |=> (v2_s2 && $stable(prod_s2[0][0]) && $stable(prod_s2[1][2])))
		else $error("stage 2 lost its transaction while held");
`endif

endmodule
